// ----- src/dccl_pkg.sv -----
// types, constants and codes shared by the directory cursor cache
package dccl_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int CNT_W   = $clog2(ENTRIES + 1);

	localparam logic [31:0] POS_INVALID = 32'hFFFF_FFFF;

	localparam logic [2:0] OP_LOOKUP  = 3'd0;
	localparam logic [2:0] OP_TRASH   = 3'd1;
	localparam logic [2:0] OP_AGE     = 3'd2;
	localparam logic [2:0] OP_SET_POS = 3'd3;
	localparam logic [2:0] OP_CLAIM   = 3'd4;

	typedef struct packed {
		logic [2:0]  operation;
		logic [7:0]  volume_id;
		logic [31:0] folder_id;
		logic [31:0] offset;
		logic [31:0] next_offset_in;
		logic [31:0] parent_id;
		logic [3:0]  entry;
	} req_t;

	typedef struct packed {
		logic [3:0] entry_out;
		logic       hit;
		logic [4:0] invalidated_count;
	} rsp_t;

	// one cursor record, cells hold them in recency order
	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [7:0]       vol;
		logic [31:0]      fld;
		logic [31:0]      cur;
		logic [31:0]      nxt;
	} rec_t;

	typedef struct packed {
		logic [7:0]       vol;
		logic [31:0]      fld;
		logic [31:0]      off;
		logic [IDX_W-1:0] idx;
	} key_t;

	typedef struct packed {
		logic lk;
		logic tr;
		logic id;
	} flags_t;

	typedef enum logic [1:0] {
		CM_HOLD = 2'd0,
		CM_PREV = 2'd1,
		CM_NEXT = 2'd2,
		CM_LOAD = 2'd3
	} cell_mode_t;

endpackage

// ----- src/dccl_ifs.sv -----
// request and response channel interfaces
interface dccl_req_if;
	logic           valid;
	logic           ready;
	dccl_pkg::req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface dccl_rsp_if;
	logic           valid;
	logic           ready;
	dccl_pkg::rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- src/dccl_cell.sv -----
// one cursor cell of the recency chain with its own tag compares
module dccl_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [dccl_pkg::IDX_W-1:0]    home,
	input  dccl_pkg::cell_mode_t          mode,
	input  dccl_pkg::rec_t                prev_rec,
	input  dccl_pkg::rec_t                next_rec,
	input  dccl_pkg::rec_t                ld_rec,
	input  dccl_pkg::key_t                key,
	output dccl_pkg::rec_t                rec,
	output dccl_pkg::flags_t              flags
);

	dccl_pkg::rec_t rec_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q     <= '0;
			rec_q.idx <= home;
		end else begin
			case (mode)
				dccl_pkg::CM_PREV: rec_q <= prev_rec;
				dccl_pkg::CM_NEXT: rec_q <= next_rec;
				dccl_pkg::CM_LOAD: rec_q <= ld_rec;
				default:           rec_q <= rec_q;
			endcase
		end
	end

	assign rec = rec_q;

	always_comb begin
		flags.lk = (rec_q.vol == key.vol) && (rec_q.fld == key.fld) &&
			((rec_q.cur == key.off) || (rec_q.nxt == key.off));
		// folder zero on trash matches every folder
		flags.tr = (rec_q.vol == key.vol) && ((key.fld == 32'd0) || (rec_q.fld == key.fld));
		flags.id = (rec_q.idx == key.idx);
	end

endmodule

// ----- src/directory_cursor_lru_cache.sv -----
// directory cursor cache: chain of cells in recency order plus scan control
//
//  channel | dir | payload
//  req     | in  | operation, volume_id, folder_id, offset, next_offset_in, parent_id, entry
//  rsp     | out | entry_out, hit, invalidated_count
//
// one word at a time; the scan pointer walks the cell chain one cell a cycle
// lookup: accept, scan, move, then response
// age, set position, claim with an owner: accept, scan, move, response; trash: accept, trash walk, response
// reset puts entry i at recency i with empty tags and no long-name owner
// a stalled response holds the block; req.ready is low until it is taken
module directory_cursor_lru_cache (
	input logic     clk,
	input logic     arst_n,
	dccl_req_if.sink   req,
	dccl_rsp_if.source rsp
);

	localparam int N  = dccl_pkg::ENTRIES;
	localparam int IW = dccl_pkg::IDX_W;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SCAN  = 5'b00010,
		S_TRASH = 5'b00100,
		S_MOVE  = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	typedef enum logic [1:0] {
		MV_MRU   = 2'd0,
		MV_LRU   = 2'd1,
		MV_WRITE = 2'd2
	} mv_kind_t;

	state_t state_q;

	logic [2:0]              op_q;
	logic [7:0]              vol_q;
	logic [31:0]             fld_q;
	logic [31:0]             off_q;
	logic [31:0]             nxt_q;
	logic [31:0]             par_q;
	logic [3:0]              ent_q;
	logic [3:0]              ent_out_q;
	logic                    hit_q;
	logic [dccl_pkg::CNT_W-1:0] cnt_q;
	logic [IW-1:0]           p_q;
	logic [IW-1:0]           t_q;
	logic [IW-1:0]           owner_q;
	logic                    owned_q;

	dccl_pkg::rec_t       recs [N];
	dccl_pkg::flags_t     fl [N];
	dccl_pkg::cell_mode_t modes [N];
	dccl_pkg::rec_t       ld;
	dccl_pkg::rec_t       sel;
	dccl_pkg::flags_t     fl_sel;
	dccl_pkg::key_t       key;

	logic     mv_en;
	mv_kind_t mv_kind;
	logic     ent_ok;
	logic [IW-1:0] ent_idx;

	localparam logic [IW-1:0] LAST = IW'(N - 1);

	assign ent_ok  = ({28'd0, req.data.entry} < 32'(N));
	assign ent_idx = IW'(ent_q);

	assign sel    = recs[p_q];
	assign fl_sel = fl[p_q];

	always_comb begin
		key.vol = vol_q;
		key.fld = fld_q;
		key.off = off_q;
		key.idx = (op_q == dccl_pkg::OP_CLAIM) ? owner_q : ent_idx;
	end

	// move request and load word for the chain
	always_comb begin
		mv_en   = 1'b0;
		mv_kind = MV_MRU;
		ld      = sel;
		if (state_q == S_TRASH) begin
			mv_en   = fl_sel.tr;
			mv_kind = MV_LRU;
			ld.vol  = 8'd0;
			ld.fld  = 32'd0;
		end else if (state_q == S_MOVE) begin
			mv_en = 1'b1;
			case (op_q)
				dccl_pkg::OP_LOOKUP: begin
					mv_kind = MV_MRU;
					if (!hit_q) begin
						ld.vol = vol_q;
						ld.fld = fld_q;
						ld.cur = dccl_pkg::POS_INVALID;
						ld.nxt = dccl_pkg::POS_INVALID;
					end
				end
				dccl_pkg::OP_AGE: mv_kind = MV_LRU;
				dccl_pkg::OP_SET_POS: begin
					mv_kind = MV_WRITE;
					ld.cur  = off_q;
					ld.nxt  = (par_q != sel.fld) ? dccl_pkg::POS_INVALID : nxt_q;
				end
				dccl_pkg::OP_CLAIM: begin
					mv_kind = MV_LRU;
					ld.vol  = 8'd0;
					ld.fld  = 32'd0;
				end
				default: mv_en = 1'b0;
			endcase
		end
	end

	always_comb begin
		for (int k = 0; k < N; k++) begin
			modes[k] = dccl_pkg::CM_HOLD;
			if (mv_en) begin
				case (mv_kind)
					MV_MRU: begin
						if (k == 0)
							modes[k] = dccl_pkg::CM_LOAD;
						else if (IW'(k) <= p_q)
							modes[k] = dccl_pkg::CM_PREV;
					end
					MV_LRU: begin
						if (k == N - 1)
							modes[k] = dccl_pkg::CM_LOAD;
						else if (IW'(k) >= p_q)
							modes[k] = dccl_pkg::CM_NEXT;
					end
					MV_WRITE: begin
						if (IW'(k) == p_q)
							modes[k] = dccl_pkg::CM_LOAD;
					end
					default: modes[k] = dccl_pkg::CM_HOLD;
				endcase
			end
		end
	end

	for (genvar g = 0; g < N; g++) begin : g_cell
		dccl_pkg::rec_t prev_r;
		dccl_pkg::rec_t next_r;
		if (g == 0) begin : g_first
			assign prev_r = recs[g];
		end else begin : g_mid_p
			assign prev_r = recs[g-1];
		end
		if (g == N - 1) begin : g_last
			assign next_r = recs[g];
		end else begin : g_mid_n
			assign next_r = recs[g+1];
		end
		dccl_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.home     (IW'(g)),
			.mode     (modes[g]),
			.prev_rec (prev_r),
			.next_rec (next_r),
			.ld_rec   (ld),
			.key      (key),
			.rec      (recs[g]),
			.flags    (fl[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			owner_q <= '0;
			owned_q <= 1'b0;
			p_q     <= '0;
			t_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						op_q      <= req.data.operation;
						vol_q     <= req.data.volume_id;
						fld_q     <= req.data.folder_id;
						off_q     <= req.data.offset;
						nxt_q     <= req.data.next_offset_in;
						par_q     <= req.data.parent_id;
						ent_q     <= req.data.entry;
						ent_out_q <= req.data.entry;
						hit_q     <= 1'b0;
						cnt_q     <= '0;
						p_q       <= '0;
						t_q       <= '0;
						case (req.data.operation)
							dccl_pkg::OP_LOOKUP: state_q <= S_SCAN;
							dccl_pkg::OP_TRASH:  state_q <= S_TRASH;
							dccl_pkg::OP_AGE,
							dccl_pkg::OP_SET_POS: state_q <= ent_ok ? S_SCAN : S_DONE;
							dccl_pkg::OP_CLAIM: begin
								if (!ent_ok ||
									(owned_q && owner_q == IW'(req.data.entry)))
									state_q <= S_DONE;
								else if (owned_q)
									state_q <= S_SCAN;
								else begin
									owner_q <= IW'(req.data.entry);
									owned_q <= 1'b1;
									state_q <= S_DONE;
								end
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_SCAN: begin
					if (op_q == dccl_pkg::OP_LOOKUP) begin
						if (fl_sel.lk) begin
							hit_q   <= 1'b1;
							state_q <= S_MOVE;
						end else if (p_q == LAST)
							state_q <= S_MOVE;
						else
							p_q <= p_q + 1'b1;
					end else if (fl_sel.id)
						state_q <= S_MOVE;
					else
						p_q <= p_q + 1'b1;
				end
				S_TRASH: begin
					// a match moves to the tail, so the pointer stays put
					if (fl_sel.tr)
						cnt_q <= cnt_q + 1'b1;
					else
						p_q <= p_q + 1'b1;
					if (t_q == LAST)
						state_q <= S_DONE;
					else
						t_q <= t_q + 1'b1;
				end
				S_MOVE: begin
					if (op_q == dccl_pkg::OP_LOOKUP) begin
						ent_out_q <= 4'(sel.idx);
						if (!hit_q && owned_q && owner_q == sel.idx)
							owned_q <= 1'b0;
					end
					if (op_q == dccl_pkg::OP_CLAIM) begin
						cnt_q   <= dccl_pkg::CNT_W'(1);
						owner_q <= ent_idx;
						owned_q <= 1'b1;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (rsp.ready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req.ready                   = (state_q == S_IDLE);
	assign rsp.valid                   = (state_q == S_DONE);
	assign rsp.data.entry_out          = ent_out_q;
	assign rsp.data.hit                = hit_q;
	assign rsp.data.invalidated_count  = 5'(cnt_q);

endmodule

// ----- src/dccl_checker.sv -----
// port-level checks for the directory cursor cache, bound to the top level
module dccl_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input dccl_pkg::rsp_t rsp_data
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("response word changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !req_ready)
		else $error("request taken while a response waits");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready && !rsp_valid ||
			!req_ready && rsp_valid)
		else $error("ready stayed high after accepting a word");

	a_hit_no_trash: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.hit |-> rsp_data.invalidated_count == 5'd0)
		else $error("hit reported together with trashed entries");

endmodule

bind directory_cursor_lru_cache dccl_checker u_dccl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);

// ----- tb/dccl_checker.sv -----
// checker for the directory cursor cache: cursor table predictor and response compare
module dccl_scoreboard (
	input logic        clk,
	input logic        arst_n,
	dccl_req_if.sink   req_mon,
	dccl_rsp_if.sink   rsp_mon,
	output int         fail_count,
	output int         pending_count,
	output int         hit_count,
	output int         trash_total
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [7:0]      vol_tag [dccl_pkg::ENTRIES];
	logic [31:0]     fld_tag [dccl_pkg::ENTRIES];
	logic [31:0]     cur_pos [dccl_pkg::ENTRIES];
	logic [31:0]     nxt_pos [dccl_pkg::ENTRIES];
	int              rank    [dccl_pkg::ENTRIES];
	int              name_owner;
	bit              name_owned;
	dccl_pkg::rsp_t  expected_rsps [$];

	assign pending_count = expected_rsps.size();

	function automatic void promote(int e);
		int r;
		r = rank[e];
		for (int i = 0; i < dccl_pkg::ENTRIES; i++)
			if (rank[i] < r) rank[i]++;
		rank[e] = 0;
	endfunction

	function automatic void demote(int e);
		int r;
		r = rank[e];
		for (int i = 0; i < dccl_pkg::ENTRIES; i++)
			if (rank[i] > r) rank[i]--;
		rank[e] = dccl_pkg::ENTRIES - 1;
	endfunction

	function automatic dccl_pkg::rsp_t predict_cursor(dccl_pkg::req_t w);
		dccl_pkg::rsp_t res;
		int          ord [dccl_pkg::ENTRIES];
		bit          hitm [dccl_pkg::ENTRIES];
		bit          found;
		int          e;
		int          r;
		res.entry_out = w.entry;
		res.hit = 1'b0;
		res.invalidated_count = '0;
		for (int i = 0; i < dccl_pkg::ENTRIES; i++) ord[rank[i]] = i;
		case (w.operation)
			dccl_pkg::OP_LOOKUP: begin
				found = 0;
				e = ord[dccl_pkg::ENTRIES-1];
				for (int i = 0; i < dccl_pkg::ENTRIES && !found; i++)
					if (vol_tag[ord[i]] == w.volume_id && fld_tag[ord[i]] == w.folder_id &&
						(cur_pos[ord[i]] == w.offset || nxt_pos[ord[i]] == w.offset)) begin
						found = 1;
						e = ord[i];
					end
				if (!found) begin
					vol_tag[e] = w.volume_id;
					fld_tag[e] = w.folder_id;
					cur_pos[e] = dccl_pkg::POS_INVALID;
					nxt_pos[e] = dccl_pkg::POS_INVALID;
					if (name_owned && name_owner == e) name_owned = 0;
				end
				promote(e);
				res.entry_out = e[3:0];
				res.hit = found;
			end
			dccl_pkg::OP_TRASH: begin
				r = 0;
				for (int i = 0; i < dccl_pkg::ENTRIES; i++) begin
					hitm[i] = vol_tag[ord[i]] == w.volume_id &&
						(w.folder_id == 0 || fld_tag[ord[i]] == w.folder_id);
					if (hitm[i]) begin
						vol_tag[ord[i]] = '0;
						fld_tag[ord[i]] = '0;
						res.invalidated_count++;
					end
				end
				for (int i = 0; i < dccl_pkg::ENTRIES; i++) if (!hitm[i]) rank[ord[i]] = r++;
				for (int i = 0; i < dccl_pkg::ENTRIES; i++) if (hitm[i]) rank[ord[i]] = r++;
			end
			dccl_pkg::OP_AGE: if (w.entry < dccl_pkg::ENTRIES) demote(w.entry);
			dccl_pkg::OP_SET_POS: if (w.entry < dccl_pkg::ENTRIES) begin
				cur_pos[w.entry] = w.offset;
				nxt_pos[w.entry] = (w.parent_id != fld_tag[w.entry]) ? dccl_pkg::POS_INVALID
					: w.next_offset_in;
			end
			dccl_pkg::OP_CLAIM: if (w.entry < dccl_pkg::ENTRIES &&
				!(name_owned && name_owner == w.entry)) begin
				if (name_owned) begin
					demote(name_owner);
					vol_tag[name_owner] = '0;
					fld_tag[name_owner] = '0;
					res.invalidated_count = 5'd1;
				end
				name_owner = w.entry;
				name_owned = 1;
			end
			default: ;
		endcase
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		dccl_pkg::rsp_t want;
		if (!arst_n) begin
			for (int i = 0; i < dccl_pkg::ENTRIES; i++) begin
				vol_tag[i] = '0;
				fld_tag[i] = '0;
				cur_pos[i] = '0;
				nxt_pos[i] = '0;
				rank[i] = i;
			end
			name_owner = 0;
			name_owned = 0;
			expected_rsps.delete();
			fail_count = 0;
			hit_count = 0;
			trash_total = 0;
		end else begin
			// response first: a word cannot come back in the cycle it was taken
			if (rsp_mon.valid && rsp_mon.ready) begin
				if (expected_rsps.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected response word %p", rsp_mon.data);
				end else begin
					want = expected_rsps.pop_front();
					if (want.hit) hit_count++;
					trash_total += want.invalidated_count;
					if (rsp_mon.data.entry_out !== want.entry_out ||
						rsp_mon.data.hit !== want.hit ||
						rsp_mon.data.invalidated_count !== want.invalidated_count) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"mismatch: expected entry %0d hit %0d count %0d,",
								" got entry %0d hit %0d count %0d"},
								want.entry_out, want.hit, want.invalidated_count,
								rsp_mon.data.entry_out, rsp_mon.data.hit,
								rsp_mon.data.invalidated_count);
					end
				end
			end
			if (req_mon.valid && req_mon.ready)
				expected_rsps.push_back(predict_cursor(req_mon.data));
		end
	end

endmodule

// ----- tb/tb_directory_cursor_lru_cache.sv -----
// top of the directory cursor cache testbench: stimulus, flow control and verdict
module tb_directory_cursor_lru_cache;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 600000;

	logic clk;
	logic arst_n;
	int   fail_count, pending_count, hit_count, trash_total;
	int   send_idle_pct, recv_idle_pct;
	bit   recv_hold;
	int   cycles;
	int   sent;

	dccl_req_if req ();
	dccl_rsp_if rsp ();

	directory_cursor_lru_cache u_dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	dccl_scoreboard u_chk (
		.clk(clk), .arst_n(arst_n), .req_mon(req), .rsp_mon(rsp),
		.fail_count(fail_count), .pending_count(pending_count),
		.hit_count(hit_count), .trash_total(trash_total)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycles);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		rsp.ready = 0;
		forever begin
			@(posedge clk);
			rsp.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// small pools so hits and trash matches are common
	function automatic dccl_pkg::req_t rand_word();
		dccl_pkg::req_t w;
		w.operation = $urandom_range(99) < 55 ? dccl_pkg::OP_LOOKUP : 3'($urandom_range(4));
		if ($urandom_range(49) == 0) w.operation = 3'($urandom_range(7));
		w.volume_id = $urandom_range(9) == 0 ? 8'($urandom) : 8'($urandom_range(1, 3));
		w.folder_id = $urandom_range(9) == 0 ? $urandom : 32'($urandom_range(0, 3));
		w.offset = $urandom_range(9) == 0 ? $urandom
			: ($urandom_range(7) == 0 ? dccl_pkg::POS_INVALID : 32'($urandom_range(0, 4)));
		w.next_offset_in = $urandom_range(9) == 0 ? $urandom : 32'($urandom_range(0, 4));
		w.parent_id = $urandom_range(3) == 0 ? $urandom : 32'($urandom_range(0, 3));
		w.entry = 4'($urandom);
		return w;
	endfunction

	function automatic dccl_pkg::req_t mk(logic [2:0] op, logic [7:0] v, logic [31:0] f,
		logic [31:0] o, logic [31:0] n, logic [31:0] p, logic [3:0] e);
		dccl_pkg::req_t w;
		w.operation = op; w.volume_id = v; w.folder_id = f; w.offset = o;
		w.next_offset_in = n; w.parent_id = p; w.entry = e;
		return w;
	endfunction

	task automatic send_word(dccl_pkg::req_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 0;
			@(posedge clk);
		end
		req.valid <= 1;
		req.data <= w;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
	endtask

	task automatic drain();
		req.valid <= 0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
	endtask

	initial begin
		dccl_pkg::req_t directed [$];
		req.valid = 0;
		req.data = '0;
		recv_hold = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		sent = 0;
		arst_n = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// extremes, every operation, owner recycling, own claim, bad ops, volume zero
		directed.push_back(mk(dccl_pkg::OP_LOOKUP, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0, 4'd0));
		directed.push_back(mk(dccl_pkg::OP_LOOKUP, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'd0, 32'd0, 4'hF));
		directed.push_back(mk(dccl_pkg::OP_LOOKUP, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'd0, 32'd0, 4'd0));
		directed.push_back(mk(dccl_pkg::OP_SET_POS, 8'd0, 32'd0, 32'd5, 32'd6,
			32'hFFFF_FFFF, 4'd14));
		directed.push_back(mk(dccl_pkg::OP_SET_POS, 8'd0, 32'd0, 32'd7, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 4'd15));
		directed.push_back(mk(dccl_pkg::OP_LOOKUP, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'd0, 32'd0, 4'd0));
		directed.push_back(mk(dccl_pkg::OP_CLAIM, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0, 4'd15));
		directed.push_back(mk(dccl_pkg::OP_CLAIM, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0, 4'd15));
		directed.push_back(mk(dccl_pkg::OP_CLAIM, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0, 4'd3));
		directed.push_back(mk(dccl_pkg::OP_AGE, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0, 4'd3));
		directed.push_back(mk(dccl_pkg::OP_LOOKUP, 8'd1, 32'd9, 32'd1, 32'd0, 32'd0, 4'd0));
		directed.push_back(mk(dccl_pkg::OP_AGE, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0, 4'd0));
		directed.push_back(mk(dccl_pkg::OP_TRASH, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0, 4'd0));
		directed.push_back(mk(dccl_pkg::OP_TRASH, 8'hFF, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0,
			4'd0));
		directed.push_back(mk(3'd5, 8'hAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
			32'hAAAA_AAAA, 4'hA));
		directed.push_back(mk(3'd6, 8'h55, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
			32'h5555_5555, 4'h5));
		directed.push_back(mk(3'd7, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0, 4'd0));
		directed.push_back(mk(dccl_pkg::OP_TRASH, 8'd1, 32'd0, 32'd0, 32'd0, 32'd0, 4'd0));
		foreach (directed[i]) send_word(directed[i]);
		drain();

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = phase == 0 ? 29 : (phase == 1 ? 54 : 0);
			recv_idle_pct = phase == 0 ? 54 : (phase == 1 ? 29 : 0);
			for (int i = 0; i < 400; i++) begin
				if (phase == 2 && i == 100) begin
					fork
						begin
							recv_hold = 1;
							repeat (300) @(posedge clk);
							recv_hold = 0;
						end
					join_none
				end
				if (i == 200) drain();
				send_word(rand_word());
				sent++;
			end
			drain();
		end
		repeat (60) @(posedge clk);

		$display("covered %0d random words plus directed set, %0d lookup hits, %0d entries trashed",
			sent, hit_count, trash_total);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
